### hw/rtl/sas_pkg.sv
// Shared types and constants for the sprite animation sequencer.
// No dependencies; imported by the controller, datapath and top level.
package sas_pkg;

    // Input beat and result beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] delta_time;
        logic [31:0] start_position;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [4:0] frame;
        logic       frame_changed;
        logic       playing;
        logic       last;
    } out_item_t;

    // Item kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_PLAY   = 3'd1;
    localparam logic [2:0] KIND_STOP   = 3'd2;
    localparam logic [2:0] KIND_PAUSE  = 3'd3;
    localparam logic [2:0] KIND_RESUME = 3'd4;

    // Wrap modes
    localparam logic [2:0] WRAP_LOOP    = 3'd0;
    localparam logic [2:0] WRAP_SECTION = 3'd1;
    localparam logic [2:0] WRAP_ONCE    = 3'd2;
    localparam logic [2:0] WRAP_PING    = 3'd3;
    localparam logic [2:0] WRAP_SINGLE  = 3'd4;

    // Result kinds
    localparam logic [1:0] RES_STATUS   = 2'd0;
    localparam logic [1:0] RES_TRIGGER  = 2'd1;
    localparam logic [1:0] RES_COMPLETE = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
    localparam logic [2:0] REG_LOOP_START  = 3'd1;
    localparam logic [2:0] REG_WRAP_MODE   = 3'd2;
    localparam logic [2:0] REG_FRAME_RATE  = 3'd3;
    localparam logic [2:0] REG_TRIG_MASK   = 3'd4;
    localparam logic [2:0] REG_TRIG_EN     = 3'd5;

    localparam int DIV_STEPS = 16;

    // Signed frame number; minus one means no frame
    typedef logic signed [7:0] frame_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SIMPLE, S_PLAY, S_MUL, S_ADD, S_PREP,
        S_DIV, S_FOLD, S_SEG, S_WALK, S_COMP, S_FLUSH
    } state_t;

    typedef struct packed {
        logic capture;
        logic simple;
        logic play;
        logic mul;
        logic add;
        logic prep;
        logic div_step;
        logic fold;
        logic seg_load;
        logic walk_step;
        logic comp;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic kind_tick;
        logic kind_play;
        logic active;
        logic div_done;
        logic seg_avail;
        logic seg_ok;
        logic comp_pend;
        logic hit;
        logic seg_end;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/sas_ctrl.sv
// Sequencing state machine of the sprite animation sequencer.
// Depends on sas_pkg; drives commands into sas_dp and reads its status.
module sas_ctrl import sas_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_DECODE;
            S_DECODE: begin
                if (sts.kind_tick && sts.active) state_next = S_MUL;
                else if (sts.kind_play)          state_next = S_PLAY;
                else                             state_next = S_SIMPLE;
            end
            S_SIMPLE: state_next = S_FLUSH;
            S_PLAY:   state_next = S_PREP;
            S_MUL:    state_next = S_ADD;
            S_ADD:    state_next = S_PREP;
            S_PREP:   state_next = S_DIV;
            S_DIV:    if (sts.div_done) state_next = S_FOLD;
            S_FOLD:   state_next = S_SEG;
            S_SEG: begin
                if (sts.seg_avail) begin
                    if (sts.seg_ok) state_next = S_WALK;
                end else if (sts.comp_pend) begin
                    state_next = S_COMP;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_WALK:   if ((!sts.hit || sts.out_free) && sts.seg_end) state_next = S_SEG;
            S_COMP:   if (sts.out_free) state_next = S_FLUSH;
            S_FLUSH:  if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_SIMPLE: cmd.simple   = 1'b1;
            S_PLAY:   cmd.play     = 1'b1;
            S_MUL:    cmd.mul      = 1'b1;
            S_ADD:    cmd.add      = 1'b1;
            S_PREP:   cmd.prep     = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_FOLD:   cmd.fold     = 1'b1;
            S_SEG:    cmd.seg_load = sts.seg_avail;
            S_WALK:   cmd.walk_step = !sts.hit || sts.out_free;
            S_COMP:   cmd.comp     = sts.out_free;
            S_FLUSH:  cmd.flush    = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

### hw/rtl/sas_dp.sv
// Datapath of the sprite animation sequencer: registers, position math,
// remainder unit, trigger walker and result register. Depends on sas_pkg.
module sas_dp import sas_pkg::*; #(
    parameter int MAX_FRAMES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_item_t    s_data,
    output out_item_t   m_data,
    output logic        m_valid,
    input  logic        m_ready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  cmd_t        cmd,
    output sts_t        sts
);

    // Configuration
    logic [5:0]  fc_reg;
    logic [4:0]  ls_reg;
    logic [2:0]  wm_reg;
    logic [15:0] rate_reg;
    logic [31:0] mask_reg;
    logic        ten_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg   <= 6'd1;
            ls_reg   <= 5'd0;
            wm_reg   <= WRAP_LOOP;
            rate_reg <= 16'd7680;
            mask_reg <= '0;
            ten_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_COUNT: fc_reg   <= cfg_wdata[5:0];
                REG_LOOP_START:  ls_reg   <= cfg_wdata[4:0];
                REG_WRAP_MODE:   wm_reg   <= cfg_wdata[2:0];
                REG_FRAME_RATE:  rate_reg <= cfg_wdata[15:0];
                REG_TRIG_MASK:   mask_reg <= cfg_wdata;
                REG_TRIG_EN:     ten_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Effective clip geometry
    logic [6:0] n7;
    logic [5:0] lse;
    logic [2:0] wm_eff;
    always_comb begin
        if (fc_reg == 6'd0)                    n7 = 7'd1;
        else if ({1'b0, fc_reg} > 7'(MAX_FRAMES)) n7 = 7'(MAX_FRAMES);
        else                                   n7 = {1'b0, fc_reg};
        lse    = ({2'b0, ls_reg} > (n7 - 7'd1)) ? 6'(n7 - 7'd1) : {1'b0, ls_reg};
        wm_eff = (wm_reg > WRAP_SINGLE) ? WRAP_LOOP : wm_reg;
    end

    frame_t ns, lss;
    assign ns  = $signed({1'b0, n7});
    assign lss = $signed({2'b0, lse});

    // Item and playback state
    logic [2:0]  kind_reg;
    logic [15:0] dt_reg;
    logic [31:0] start_reg;
    logic [31:0] pos_reg;
    frame_t      prev_reg;
    logic        playing_reg, paused_reg;
    logic [31:0] prod_reg;

    logic [15:0] k;
    assign k = pos_reg[31:16];

    logic [32:0] sum;
    assign sum = {1'b0, pos_reg} + {9'b0, prod_reg[31:8]};

    logic start_past_end;
    assign start_past_end = start_reg[31:16] >= {9'b0, n7};

    // Remainder unit: restoring, one dividend bit per cycle
    logic [15:0] dvd_reg;
    logic [6:0]  dvs_reg, rem_reg;
    logic [4:0]  dcnt_reg;
    logic [15:0] dvd_init;
    logic [6:0]  dvs_init;
    logic [7:0]  trial;

    logic k_ge_n, k_ge_ls;
    assign k_ge_n  = k >= {9'b0, n7};
    assign k_ge_ls = k >= {10'b0, lse};

    always_comb begin
        dvd_init = k;
        dvs_init = n7;
        if (kind_reg != KIND_PLAY) begin
            case (wm_eff)
                WRAP_SECTION: begin
                    if (k_ge_ls) begin
                        dvd_init = k - {10'b0, lse};
                        dvs_init = n7 - {1'b0, lse};
                    end
                end
                WRAP_PING: dvs_init = (n7 > 7'd1) ? 7'({n7, 1'b0} - 8'd2) : 7'd1;
                default: ;
            endcase
        end
    end

    assign trial = {rem_reg, dvd_reg[15]};

    // Fold: frame shown and trigger segments
    frame_t num, rs, ks, f;
    logic   setf, comp_f;
    frame_t s0, l0, s1, l1;
    logic   d0, d1;
    logic [1:0] cnt_f;

    assign num = prev_reg;
    assign rs  = $signed({1'b0, rem_reg});
    assign ks  = $signed({2'b0, k[5:0]});

    always_comb begin
        f = '0; setf = 1'b0; comp_f = 1'b0;
        s0 = '0; l0 = '0; d0 = 1'b0;
        s1 = '0; l1 = '0; d1 = 1'b0;
        cnt_f = 2'd0;
        if (kind_reg == KIND_PLAY) begin
            f = rs; setf = 1'b1;
            s0 = rs - 8'sd1; l0 = rs; cnt_f = 2'd1;
        end else begin
            case (wm_eff)
                WRAP_SECTION: begin
                    setf = 1'b1;
                    if (k_ge_ls) begin
                        f = lss + rs;
                        if (num < lss) begin
                            s0 = num; l0 = lss - 8'sd1;
                            s1 = lss - 8'sd1; l1 = f; cnt_f = 2'd2;
                        end else if (f < num) begin
                            s0 = num; l0 = ns - 8'sd1;
                            s1 = lss - 8'sd1; l1 = f; cnt_f = 2'd2;
                        end else begin
                            s0 = num; l0 = f; cnt_f = 2'd1;
                        end
                    end else begin
                        f = ks; s0 = num; l0 = ks; cnt_f = 2'd1;
                    end
                end
                WRAP_PING: begin
                    setf = 1'b1;
                    if (n7 > 7'd1) begin
                        if (rs >= ns) begin
                            f = (ns <<< 1) - 8'sd2 - rs; d0 = 1'b1;
                        end else begin
                            f = rs;
                        end
                    end
                    if (f < num) d0 = 1'b1;
                    s0 = num; l0 = f; cnt_f = 2'd1;
                end
                WRAP_ONCE: begin
                    setf = 1'b1;
                    if (k_ge_n) begin
                        f = ns - 8'sd1; comp_f = 1'b1;
                    end else begin
                        f = ks;
                    end
                    s0 = num; l0 = f; cnt_f = 2'd1;
                end
                WRAP_SINGLE: ;
                default: begin
                    setf = 1'b1; f = rs;
                    if (f < num) begin
                        s0 = num; l0 = ns - 8'sd1;
                        s1 = -8'sd1; l1 = f; cnt_f = 2'd2;
                    end else begin
                        s0 = num; l0 = f; cnt_f = 2'd1;
                    end
                end
            endcase
        end
    end

    // Segments and walker
    frame_t     seg_s_reg [2];
    frame_t     seg_l_reg [2];
    logic       seg_d_reg [2];
    logic [1:0] seg_cnt_reg;
    logic [1:0] seg_idx_reg;
    logic       comp_reg;
    frame_t     cur_reg, last_reg;
    logic       down_reg;

    frame_t sel_s, sel_l, nxt;
    logic   sel_d;
    assign sel_s = seg_s_reg[seg_idx_reg[0]];
    assign sel_l = seg_l_reg[seg_idx_reg[0]];
    assign sel_d = seg_d_reg[seg_idx_reg[0]];
    assign nxt   = down_reg ? cur_reg - 8'sd1 : cur_reg + 8'sd1;

    // Pending result, sent once the next one is known
    logic [1:0] pend_kind_reg;
    logic [4:0] pend_frame_reg;
    logic       pend_chg_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic       out_free;
    logic       emit, emit_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (cmd.walk_step && sts.hit) || cmd.comp || cmd.flush;
    assign emit_last = cmd.flush;

    logic [4:0] prev_frame5;
    assign prev_frame5 = (num < 0) ? 5'd0 : num[4:0];

    always_comb begin
        sts.kind_tick = kind_reg == KIND_TICK;
        sts.kind_play = kind_reg == KIND_PLAY;
        sts.active    = playing_reg && !paused_reg;
        sts.div_done  = dcnt_reg == 5'd0;
        sts.seg_avail = seg_idx_reg < seg_cnt_reg;
        sts.seg_ok    = ten_reg && (sel_s != sel_l) && ((sel_l > sel_s) == !sel_d);
        sts.comp_pend = comp_reg;
        sts.hit       = (nxt >= 0) && (nxt < 8'sd32) && (nxt < ns) && mask_reg[nxt[4:0]];
        sts.seg_end   = nxt == last_reg;
        sts.out_free  = out_free;
    end

    // Control-bearing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= -8'sd1;
            playing_reg <= 1'b0;
            paused_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            dcnt_reg    <= '0;
            seg_cnt_reg <= '0;
            seg_idx_reg <= 2'd0;
            comp_reg    <= 1'b0;
        end else begin
            if (emit)         m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            if (cmd.simple) begin
                case (kind_reg)
                    KIND_STOP:   playing_reg <= 1'b0;
                    KIND_PAUSE:  paused_reg  <= 1'b1;
                    KIND_RESUME: paused_reg  <= 1'b0;
                    default: ;
                endcase
            end
            if (cmd.play)
                playing_reg <= !((wm_eff == WRAP_SINGLE) ||
                                 ((wm_eff == WRAP_ONCE) && start_past_end));
            if (cmd.prep)     dcnt_reg <= 5'(DIV_STEPS);
            if (cmd.div_step && dcnt_reg != 5'd0) dcnt_reg <= dcnt_reg - 5'd1;
            if (cmd.fold) begin
                seg_cnt_reg <= cnt_f;
                seg_idx_reg <= 2'd0;
                comp_reg    <= comp_f;
                if (comp_f) begin
                    prev_reg    <= -8'sd1;
                    playing_reg <= 1'b0;
                end else if (setf) begin
                    prev_reg <= f;
                end
            end
            if (cmd.seg_load) seg_idx_reg <= seg_idx_reg + 2'd1;
            if (cmd.comp)     comp_reg    <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_data.kind;
            dt_reg    <= s_data.delta_time;
            start_reg <= s_data.start_position;
        end
        if (cmd.mul) prod_reg <= {16'b0, dt_reg} * {16'b0, rate_reg};
        if (cmd.add) pos_reg  <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (cmd.play) begin
            if (wm_eff == WRAP_SINGLE)                     pos_reg <= '0;
            else if (wm_eff == WRAP_ONCE && start_past_end) pos_reg <= {9'b0, n7 - 7'd1, 16'b0};
            else                                           pos_reg <= start_reg;
        end
        if (cmd.prep) begin
            dvd_reg <= dvd_init;
            dvs_reg <= dvs_init;
            rem_reg <= '0;
        end
        if (cmd.div_step && dcnt_reg != 5'd0) begin
            dvd_reg <= {dvd_reg[14:0], 1'b0};
            rem_reg <= (trial >= {1'b0, dvs_reg}) ? 7'(trial - {1'b0, dvs_reg}) : trial[6:0];
        end
        if (cmd.fold) begin
            seg_s_reg[0] <= s0; seg_l_reg[0] <= l0; seg_d_reg[0] <= d0;
            seg_s_reg[1] <= s1; seg_l_reg[1] <= l1; seg_d_reg[1] <= d1;
            pend_kind_reg  <= RES_STATUS;
            pend_frame_reg <= setf ? f[4:0] : prev_frame5;
            pend_chg_reg   <= setf && (num != f);
        end
        if (cmd.simple) begin
            pend_kind_reg  <= RES_STATUS;
            pend_frame_reg <= prev_frame5;
            pend_chg_reg   <= 1'b0;
        end
        if (cmd.seg_load) begin
            cur_reg  <= sel_s;
            last_reg <= sel_l;
            down_reg <= sel_d;
        end
        if (cmd.walk_step) begin
            cur_reg <= nxt;
            if (sts.hit) begin
                pend_kind_reg  <= RES_TRIGGER;
                pend_frame_reg <= nxt[4:0];
                pend_chg_reg   <= 1'b0;
            end
        end
        if (cmd.comp) begin
            pend_kind_reg  <= RES_COMPLETE;
            pend_frame_reg <= 5'(n7 - 7'd1);
            pend_chg_reg   <= 1'b0;
        end
        if (emit) begin
            m_data_reg.result_kind   <= pend_kind_reg;
            m_data_reg.frame         <= pend_frame_reg;
            m_data_reg.frame_changed <= pend_chg_reg;
            m_data_reg.playing       <= playing_reg;
            m_data_reg.last          <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/sprite_animation_sequencer.sv
// Top level of the sprite animation sequencer.
// Depends on sas_pkg, sas_ctrl and sas_dp.
//
// Plays one animation clip. Each input beat (tick, play, stop, pause, resume)
// yields a frame status result, then one trigger result per flagged frame
// crossed in the direction of travel, then a completion result when a once
// clip ends; the last result of a beat carries the last flag. One beat is
// worked at a time. A tick that advances runs a 16x16 multiply, a saturating
// add and a bit-serial remainder unit that folds the frame number, then the
// trigger walker, which loads each trigger segment and walks its frames (at
// most the clip length). A play beat skips the multiply and add; stop, pause,
// resume and idle ticks go straight to the flush. A result register sits on
// the output, so the next beat is taken while the final result waits for
// m_ready; a walk that finds triggers stalls on that register while it is
// full. Configuration is written through cfg_we, cfg_addr and cfg_wdata with no
// wait; write it only while the block is idle; the block does not enforce this.
module sprite_animation_sequencer import sas_pkg::*; #(
    parameter int MAX_FRAMES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    // Sequence the beat: decode, multiply, add, fold, walk, flush
    sas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold configuration and playback state; advance the position
    sas_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the sprite animation sequencer.
// Depends on sas_pkg and sprite_animation_sequencer; drives beats, predicts results.
`timescale 1ns / 1ps

module tb_top import sas_pkg::*; ();

    localparam int MAXF = 32;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    sprite_animation_sequencer #(.MAX_FRAMES(MAXF)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Shadow copy of the registers and the playback state
    logic [5:0]  r_count;
    logic [4:0]  r_lstart;
    logic [2:0]  r_wrap;
    logic [15:0] r_rate;
    logic [31:0] r_mask;
    logic        r_trig_en;
    logic [31:0] clip_pos;
    int          prev_frame;
    bit          is_playing;
    bit          is_paused;

    // Results still owed by the block, oldest first
    out_item_t   owed_q[$];
    out_item_t   beat_res[$];
    int          shown_frame;
    bit          shown_changed;

    bit          failed;
    bit          quiet_tail;
    bit          out_stall_on;
    int          idle_cnt;

    function automatic out_item_t mk(logic [1:0] k, int f);
        out_item_t r;
        r = '0;
        r.result_kind = k;
        r.frame = f[4:0];
        return r;
    endfunction

    function automatic void fire_trig(int i, int n);
        if (i >= 0 && i < 32 && i < n && r_mask[i]) beat_res.push_back(mk(RES_TRIGGER, i));
    endfunction

    function automatic void walk_trigs(int from, int upto, int dir, int n);
        int i;
        if (!r_trig_en || from == upto) return;
        if (((upto - from) > 0) != (dir > 0)) return;
        for (i = from + dir; i != upto + dir; i += dir) fire_trig(i, n);
    endfunction

    function automatic void show(int f);
        if (prev_frame != f) shown_changed = 1;
        prev_frame = f;
        shown_frame = f;
    endfunction

    function automatic void jump_to(logic [31:0] p, int n);
        int f;
        f = int'(p[31:16]) % n;
        clip_pos = p;
        shown_changed = (prev_frame != f);
        shown_frame = f;
        if (r_trig_en) fire_trig(f, n);
        prev_frame = f;
    endfunction

    function automatic int eff_count();
        int n;
        n = r_count;
        if (n < 1) n = 1;
        if (n > MAXF) n = MAXF;
        return n;
    endfunction

    function automatic void advance_clip(logic [15:0] dt);
        logic [31:0] inc;
        logic [32:0] sum;
        int k, num, n, ls, f, dir;
        logic [2:0] w;
        if (!is_playing || is_paused) return;
        inc = 32'((48'(dt) * 48'(r_rate)) >> 8);
        sum = {1'b0, clip_pos} + {1'b0, inc};
        clip_pos = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        k = int'(clip_pos[31:16]);
        num = prev_frame;
        n = eff_count();
        ls = r_lstart;
        if (ls > n - 1) ls = n - 1;
        w = (r_wrap <= WRAP_SINGLE) ? r_wrap : WRAP_LOOP;
        case (w)
            WRAP_LOOP: begin
                f = k % n;
                show(f);
                if (f < num) begin
                    walk_trigs(num, n - 1, 1, n);
                    walk_trigs(-1, f, 1, n);
                end else walk_trigs(num, f, 1, n);
            end
            WRAP_SECTION: begin
                if (k >= ls) begin
                    f = ls + (k - ls) % (n - ls);
                    show(f);
                    if (num < ls) begin
                        walk_trigs(num, ls - 1, 1, n);
                        walk_trigs(ls - 1, f, 1, n);
                    end else if (f < num) begin
                        walk_trigs(num, n - 1, 1, n);
                        walk_trigs(ls - 1, f, 1, n);
                    end else walk_trigs(num, f, 1, n);
                end else begin
                    show(k);
                    walk_trigs(num, k, 1, n);
                end
            end
            WRAP_PING: begin
                f = (n > 1) ? k % (2 * n - 2) : 0;
                dir = 1;
                if (f >= n) begin
                    f = 2 * n - 2 - f;
                    dir = -1;
                end
                if (f < num) dir = -1;
                show(f);
                walk_trigs(num, f, dir, n);
            end
            WRAP_ONCE: begin
                if (k >= n) begin
                    show(n - 1);
                    is_playing = 0;
                    walk_trigs(num, n - 1, 1, n);
                    beat_res.push_back(mk(RES_COMPLETE, n - 1));
                    prev_frame = -1;
                end else begin
                    show(k);
                    walk_trigs(num, k, 1, n);
                end
            end
            default: ;
        endcase
    endfunction

    // Work out the results of one beat and append them to the owed queue
    function automatic void predict_beat(in_item_t it);
        out_item_t st;
        int n, i;
        logic [2:0] w;
        beat_res.delete();
        shown_frame = -1;
        shown_changed = 0;
        case (it.kind)
            KIND_TICK: advance_clip(it.delta_time);
            KIND_PLAY: begin
                n = eff_count();
                w = (r_wrap <= WRAP_SINGLE) ? r_wrap : WRAP_LOOP;
                is_playing = 1;
                if (w == WRAP_SINGLE) begin
                    jump_to(32'd0, n);
                    is_playing = 0;
                end else if (w == WRAP_ONCE && int'(it.start_position[31:16]) >= n) begin
                    jump_to(32'(n - 1) << 16, n);
                    is_playing = 0;
                end else jump_to(it.start_position, n);
            end
            KIND_STOP:   is_playing = 0;
            KIND_PAUSE:  is_paused = 1;
            KIND_RESUME: is_paused = 0;
            default: ;
        endcase
        if (shown_frame < 0) begin
            shown_frame = prev_frame;
            shown_changed = 0;
        end
        if (shown_frame < 0) shown_frame = 0;
        st = mk(RES_STATUS, shown_frame);
        st.frame_changed = shown_changed;
        beat_res.push_front(st);
        while (beat_res.size() > 34) void'(beat_res.pop_back());
        for (i = 0; i < beat_res.size(); i++) begin
            beat_res[i].playing = is_playing;
            beat_res[i].last = (i == beat_res.size() - 1);
            owed_q.push_back(beat_res[i]);
        end
    endfunction

    // Result side: random stall bursts, compare each accepted beat
    initial begin
        int burst;
        burst = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    failed = 1;
                end else if (m_data !== owed_q[0]) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, owed_q[0], m_data);
                    failed = 1;
                    void'(owed_q.pop_front());
                end else void'(owed_q.pop_front());
            end
            if (burst > 0) burst--;
            else if (!quiet_tail && out_stall_on && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 6);
            m_ready <= (burst == 0);
        end
    end

    // Watchdog on cycles with no beat moving
    initial begin
        idle_cnt = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // Register write, mirrored into the shadow copy; the caller drops cfg_we
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_FRAME_COUNT: r_count = val[5:0];
            REG_LOOP_START:  r_lstart = val[4:0];
            REG_WRAP_MODE:   r_wrap = val[2:0];
            REG_FRAME_RATE:  r_rate = val[15:0];
            REG_TRIG_MASK:   r_mask = val;
            REG_TRIG_EN:     r_trig_en = val[0];
            default: ;
        endcase
    endtask

    task automatic setup(int cnt, int ls, int wm, int rate, logic [31:0] mask, bit en);
        write_reg(REG_FRAME_COUNT, 32'(cnt));
        write_reg(REG_LOOP_START, 32'(ls));
        write_reg(REG_WRAP_MODE, 32'(wm));
        write_reg(REG_FRAME_RATE, 32'(rate));
        write_reg(REG_TRIG_MASK, mask);
        write_reg(REG_TRIG_EN, 32'(en));
        cfg_we <= 1'b0;
    endtask

    // Send one beat; optional random gap first, hold valid until accepted
    task automatic send_beat(in_item_t it);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (owed_q.size() != 0) @(posedge aclk);
        // let a tail walk with no further results finish before touching registers
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic in_item_t mk_in(logic [2:0] k, logic [15:0] dt, logic [31:0] sp);
        in_item_t it;
        it.kind = k;
        it.delta_time = dt;
        it.start_position = sp;
        return it;
    endfunction

    function automatic in_item_t rand_item(int n);
        int sel;
        logic [2:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 62) k = KIND_TICK;
        else if (sel < 78) k = KIND_PLAY;
        else if (sel < 84) k = KIND_STOP;
        else if (sel < 90) k = KIND_PAUSE;
        else if (sel < 96) k = KIND_RESUME;
        else k = 3'($urandom_range(5, 7));
        // mostly start within a couple of clip lengths, sometimes anywhere
        if ($urandom_range(0, 5) == 0)
            return mk_in(k, 16'($urandom), $urandom);
        return mk_in(k, 16'($urandom_range(0, 16000)),
                     {16'($urandom_range(0, 2 * n)), 16'($urandom)});
    endfunction

    // Directed rows: expected status typed in where obvious, else predictor only
    typedef struct {
        in_item_t   item;
        bit         typed;
        out_item_t  want;
    } row_t;

    row_t rows[$];

    task automatic add_row(in_item_t it, bit typed, out_item_t w);
        row_t r;
        r.item = it;
        r.typed = typed;
        r.want = w;
        rows.push_back(r);
    endtask

    function automatic out_item_t st_res(int f, bit ch, bit pl);
        out_item_t r;
        r = mk(RES_STATUS, f);
        r.frame_changed = ch;
        r.playing = pl;
        r.last = 1;
        return r;
    endfunction

    initial begin
        int i, ph, n, total;
        failed = 0;
        quiet_tail = 0;
        out_stall_on = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        r_count = 6'd1; r_lstart = 5'd0; r_wrap = WRAP_LOOP; r_rate = 16'd7680;
        r_mask = '0; r_trig_en = 0;
        clip_pos = '0; prev_frame = -1; is_playing = 0; is_paused = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: tick with no frame held reports frame zero
        add_row(mk_in(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF), 1, st_res(0, 0, 0));
        add_row(mk_in(3'd7, 16'h0, 32'h0), 1, st_res(0, 0, 0));
        add_row(mk_in(KIND_PLAY, 16'h0, 32'hFFFF_FFFF), 1, st_res(0, 1, 1));
        add_row(mk_in(KIND_TICK, 16'hFFFF, 32'h0), 0, '0);
        foreach (rows[i]) begin
            send_beat(rows[i].item);
            if (rows[i].typed && owed_q[owed_q.size() - 1] !== rows[i].want) begin
                $display("%0t: directed row %0d, expected %p, predicted %p",
                         $time, i, rows[i].want, owed_q[owed_q.size() - 1]);
                failed = 1;
            end
        end
        drain();
        rows.delete();

        // Extremes: 32 frames, all triggers, max rate
        setup(32, 31, WRAP_LOOP, 65535, 32'hFFFF_FFFF, 1);
        add_row(mk_in(KIND_PLAY, 16'h0, 32'h001F_0000), 0, '0);
        add_row(mk_in(KIND_TICK, 16'hFFFF, 32'h0), 0, '0);
        add_row(mk_in(KIND_PAUSE, 16'h0, 32'h0), 0, '0);
        add_row(mk_in(KIND_TICK, 16'hFFFF, 32'h0), 0, '0);
        add_row(mk_in(KIND_RESUME, 16'h0, 32'h0), 0, '0);
        add_row(mk_in(KIND_TICK, 16'h1, 32'h0), 0, '0);
        add_row(mk_in(KIND_STOP, 16'h0, 32'h0), 0, '0);
        foreach (rows[i]) send_beat(rows[i].item);
        drain();
        rows.delete();
        // Once mode: start past the end, then run to completion
        setup(63, 31, WRAP_ONCE, 7680, 32'hAAAA_5555, 1);
        send_beat(mk_in(KIND_PLAY, 16'h0, 32'hFFFF_0000));
        send_beat(mk_in(KIND_PLAY, 16'h0, 32'h0));
        send_beat(mk_in(KIND_TICK, 16'hFFFF, 32'h0));
        send_beat(mk_in(KIND_TICK, 16'hFFFF, 32'h0));
        drain();
        // Single, section with loop start past the end, unknown wrap mode
        setup(0, 0, WRAP_SINGLE, 1, 32'h0, 0);
        send_beat(mk_in(KIND_PLAY, 16'h0, 32'h1234_5678));
        send_beat(mk_in(KIND_TICK, 16'h8000, 32'h0));
        drain();
        setup(5, 30, WRAP_SECTION, 7680, 32'h1F, 1);
        send_beat(mk_in(KIND_PLAY, 16'h0, 32'h0));
        send_beat(mk_in(KIND_TICK, 16'h4000, 32'h0));
        drain();
        setup(7, 0, 3'd7, 7680, 32'h55, 1);
        send_beat(mk_in(KIND_PLAY, 16'h0, 32'h0003_0000));
        send_beat(mk_in(KIND_TICK, 16'h1000, 32'h0));
        drain();

        // Random phases: new settings each phase, output stalls switched on
        out_stall_on = 1;
        total = 0;
        for (ph = 0; ph < 10; ph++) begin
            n = (ph % 4 == 0) ? 32 : $urandom_range(1, 10);
            if (ph == 9) quiet_tail = 1;
            setup(($urandom_range(0, 7) == 0) ? $urandom_range(33, 63) : n,
                  $urandom_range(0, 31), $urandom_range(0, 7),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535)
                                              : $urandom_range(256, 20000),
                  $urandom, $urandom_range(0, 3) != 0);
            send_beat(mk_in(KIND_RESUME, 16'h0, 32'h0));
            send_beat(mk_in(KIND_PLAY, 16'h0, {16'($urandom_range(0, n)), 16'($urandom)}));
            for (i = 0; i < 30; i++) begin
                send_beat(rand_item(n));
                // keep the clip running most of the time
                if (!is_playing && $urandom_range(0, 2) != 0)
                    send_beat(mk_in(KIND_PLAY, 16'h0, {16'($urandom_range(0, n)), 16'($urandom)}));
                if (is_paused && $urandom_range(0, 1) == 0)
                    send_beat(mk_in(KIND_RESUME, 16'h0, 32'h0));
                total++;
            end
            // hold off the sender until the block is empty
            drain();
        end

        if (!failed) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule
